/* rtl/sprite_column_post_decoder_unit_defines.svh */
// Assertion macros shared by the sprite column post decoder RTL.
`ifndef SPRITE_COLUMN_POST_DECODER_UNIT_DEFINES_SVH
`define SPRITE_COLUMN_POST_DECODER_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define SCPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SCPD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/scpd_pkg.sv */
// Shared types and constants of the sprite column post decoder.
`timescale 1ns / 1ps
`default_nettype none

package scpd_pkg;

	// Byte that closes a column
	localparam logic [7:0] END_OF_COLUMN = 8'hFF;

	// Configuration register indexes
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// Position inside a post
	typedef enum logic [2:0] {
		PH_ROW    = 3'd0,
		PH_COUNT  = 3'd1,
		PH_PAD1   = 3'd2,
		PH_PIXELS = 3'd3,
		PH_PAD2   = 3'd4
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_COL_END = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// One result from the decode stage
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [16:0] pixel_address;
		logic [7:0]  pixel_value;
		logic [8:0]  column_index;
		logic        column_overflow;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

/* rtl/scpd_cfg.sv */
// Image size registers, saturated to the build limits, and the image pixel total.
`timescale 1ns / 1ps
`default_nettype none

module scpd_cfg
	import scpd_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1),
	localparam int AW = WW + HW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [9:0]    cfg_data,
	output logic      [WW-1:0] eff_width,
	output logic      [HW-1:0] eff_height,
	output logic      [AW-1:0] total
);

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] total_q;
	logic [WW-1:0] width_sat;
	logic [HW-1:0] height_sat;
	logic [AW-1:0] product;

	// Saturate at the build limits on the way in; the height uses only cfg_data[8:0]
	assign width_sat  = (32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
	assign height_sat = (32'(cfg_data[8:0]) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
		: HW'(cfg_data[8:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(1);
			height_q <= HW'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= width_sat;
				CFG_IMAGE_HEIGHT: height_q <= height_sat;
				default: ;
			endcase
		end
	end

	// Pixel total, registered after the multiply
	assign product = {HW'(0), width_q} * {WW'(0), height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= AW'(1);
		end else begin
			total_q <= product;
		end
	end

	assign eff_width  = width_q;
	assign eff_height = height_q;
	assign total      = total_q;

endmodule

`default_nettype wire

/* rtl/scpd_dec.sv */
// Post decode state machine: column, address and count tracking per data byte.
`timescale 1ns / 1ps
`default_nettype none

module scpd_dec
	import scpd_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1),
	localparam int AW = WW + HW,
	localparam int XW = ((AW > 9) ? AW : 9) + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [7:0]    data_byte,
	input  wire logic          first_of_image,
	input  wire logic [WW-1:0] eff_width,
	input  wire logic [HW-1:0] eff_height,
	input  wire logic [AW-1:0] total,
	output res_t               res
);

	phase_t        phase_q, phase_d, cur_phase;
	logic [WW-1:0] col_q, col_d, cur_col;
	logic [AW-1:0] base_q, base_d, cur_base;
	logic [XW-1:0] wa_q, wa_d, cur_wa;
	logic [7:0]    left_q, left_d, cur_left;
	logic          ovf_q, ovf_d, cur_ovf;
	logic          halt_q, halt_d, cur_halt;

	logic [WW:0]   col_next;
	logic          is_last;
	logic [XW-1:0] row_addr;
	logic [XW-1:0] col_end;
	logic [XW-1:0] total_x;
	logic          is_eoc;

	// Start of image clears the decode state before the byte is used
	always_comb begin
		cur_phase = first_of_image ? PH_ROW : phase_q;
		cur_col   = first_of_image ? '0 : col_q;
		cur_base  = first_of_image ? '0 : base_q;
		cur_wa    = first_of_image ? '0 : wa_q;
		cur_left  = first_of_image ? '0 : left_q;
		cur_ovf   = first_of_image ? 1'b0 : ovf_q;
		cur_halt  = first_of_image ? 1'b0 : halt_q;
	end

	// Shared arithmetic
	assign col_next = {1'b0, cur_col} + (WW + 1)'(1);
	assign is_last  = col_next >= {1'b0, eff_width};
	assign row_addr = XW'(cur_base) + XW'(data_byte);
	assign col_end  = XW'(cur_base) + XW'(eff_height);
	assign total_x  = XW'(total);
	assign is_eoc   = data_byte == END_OF_COLUMN;

	// Next state
	always_comb begin
		phase_d = cur_phase;
		col_d   = cur_col;
		base_d  = cur_base;
		wa_d    = cur_wa;
		left_d  = cur_left;
		ovf_d   = cur_ovf;
		halt_d  = cur_halt;
		if (!cur_halt) begin
			unique case (cur_phase)
				PH_ROW: begin
					if (is_eoc) begin
						ovf_d = 1'b0;
						if (is_last) begin
							halt_d = 1'b1;
						end else begin
							col_d  = col_next[WW-1:0];
							base_d = cur_base + AW'(eff_height);
						end
					end else begin
						wa_d    = row_addr;
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					left_d  = data_byte;
					phase_d = PH_PAD1;
				end
				PH_PAD1: begin
					phase_d = (cur_left != 8'd0) ? PH_PIXELS : PH_PAD2;
				end
				PH_PIXELS: begin
					wa_d   = cur_wa + XW'(1);
					left_d = cur_left - 8'd1;
					if (cur_left == 8'd1) begin
						phase_d = PH_PAD2;
					end
				end
				PH_PAD2: begin
					if (cur_wa > col_end) begin
						ovf_d = 1'b1;
					end
					phase_d = PH_ROW;
					if (cur_wa > total_x) begin
						halt_d = 1'b1;
					end
				end
				default: phase_d = PH_ROW;
			endcase
		end
	end

	// Result for this byte
	always_comb begin
		res              = '0;
		res.column_index = 9'(cur_col);
		if (go && !cur_halt) begin
			unique case (cur_phase)
				PH_ROW: begin
					if (is_eoc) begin
						res.valid           = 1'b1;
						res.kind            = KIND_COL_END;
						res.column_overflow = cur_ovf;
						res.last            = is_last;
					end
				end
				PH_PIXELS: begin
					if (cur_wa < total_x) begin
						res.valid         = 1'b1;
						res.kind          = KIND_PIXEL;
						res.pixel_address = 17'(cur_wa);
						res.pixel_value   = data_byte;
					end
				end
				PH_PAD2: begin
					if (cur_wa > total_x) begin
						res.valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.last  = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// State registers, advanced once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ROW;
			col_q   <= '0;
			base_q  <= '0;
			wa_q    <= '0;
			left_q  <= '0;
			ovf_q   <= 1'b0;
			halt_q  <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			col_q   <= col_d;
			base_q  <= base_d;
			wa_q    <= wa_d;
			left_q  <= left_d;
			ovf_q   <= ovf_d;
			halt_q  <= halt_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/sprite_column_post_decoder_unit.sv */
// Top level of the sprite column post decoder: input stage, decode and result register.
// A byte taken into the input register is decoded combinationally and its result held in the result register.
// Throughput: one byte per cycle unless the result register stalls; s_axis_tready depends on m_axis_tready.
// Each byte gives zero or one result; only the result register stalls the flow.
// Reset (arst_n low, asynchronous): size registers to 1x1, decoder to row start, no result held.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_column_post_decoder_unit_defines.svh"

module sprite_column_post_decoder_unit
	import scpd_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,  // [0] first_of_image
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [16:0] pixel_address, [24:17] pixel_value,
	                                        // [33:25] column_index, [34] column_overflow,
	                                        // [39:35] zero
	output logic [1:0]       m_axis_tuser,  // [1:0] kind
	output logic             m_axis_tlast,  // last
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = WW + HW;

	logic [WW-1:0] eff_width;
	logic [HW-1:0] eff_height;
	logic [AW-1:0] total;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          first_s1;
	logic          adv;
	res_t          res;
	res_t          res_q;

	assign cfg_ready = 1'b1;

	scpd_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.total      (total)
	);

	// Stage moves whenever the result register is free or being drained
	assign adv           = !res_q.valid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser[0];
		end
	end

	scpd_dec #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dec (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (valid_s1 && adv),
		.data_byte      (byte_s1),
		.first_of_image (first_s1),
		.eff_width      (eff_width),
		.eff_height     (eff_height),
		.total          (total),
		.res            (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_q.valid;
	assign m_axis_tdata  = {5'd0, res_q.column_overflow, res_q.column_index,
		res_q.pixel_value, res_q.pixel_address};
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = res_q.last;

	`SCPD_ASSERT_RST(a_no_result_in_reset, !arst_n |-> !m_axis_tvalid,
		"result valid while in reset")
	`SCPD_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
		"input stalled with empty result register")
	`SCPD_ASSERT(a_error_is_last,
		(m_axis_tvalid && m_axis_tuser == KIND_ERROR) |-> m_axis_tlast,
		"error result without last")
	`SCPD_ASSERT(a_pixel_not_last,
		(m_axis_tvalid && m_axis_tuser == KIND_PIXEL) |-> (!m_axis_tlast && !m_axis_tdata[34]),
		"pixel write carries column end flags")

endmodule

`default_nettype wire
